// File: rtl/kcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcr_pkg
// Types, sizes and the identity function shared by the chord remapper.
// ----------------------------------------------------------------------------
package kcr_pkg;

  localparam int RULE_SLOTS    = 32;
  localparam int HELD_SLOTS    = 16;
  localparam int KEY_CODE_BITS = 10;

  localparam int CP_BITS    = 21;
  localparam int MOD_BITS   = 16;
  localparam int TCP_BITS   = 7;
  localparam int IDENT_BITS = 22;
  localparam int CFG_BITS   = (MOD_BITS > KEY_CODE_BITS) ? MOD_BITS : KEY_CODE_BITS;

  localparam int RULE_IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int HELD_IW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
  localparam int CNT_W   = (RULE_IW > HELD_IW) ? RULE_IW : HELD_IW;

  localparam logic [IDENT_BITS-1:0] NAMED_BASE = IDENT_BITS'(22'h200000);
  localparam logic [CP_BITS-1:0]    CP_MAX_ASCII = CP_BITS'(8'h7e);
  localparam logic [CP_BITS-1:0]    CP_UPPER_A   = CP_BITS'(8'h41);
  localparam logic [CP_BITS-1:0]    CP_UPPER_Z   = CP_BITS'(8'h5a);
  localparam logic [CP_BITS-1:0]    CP_LOWER_A   = CP_BITS'(8'h61);

  localparam logic [1:0] FUNC_EVENT = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_RULE_FULL  = 2'd1;
  localparam logic [1:0] ST_HELD_FULL  = 2'd2;
  localparam logic [1:0] ST_NO_IDENT   = 2'd3;

  localparam logic [1:0] CFG_LOCK_MASK = 2'd0;
  localparam logic [1:0] CFG_PRINT_KEY = 2'd1;
  localparam logic [1:0] CFG_UNK_KEY   = 2'd2;

  typedef struct packed {
    logic [1:0]               func;
    logic [1:0]               action;
    logic [KEY_CODE_BITS-1:0] key_code;
    logic [MOD_BITS-1:0]      modifiers;
    logic [CP_BITS-1:0]       base_codepoint;
    logic [CP_BITS-1:0]       layout_codepoint;
    logic [CP_BITS-1:0]       shifted_codepoint;
    logic                     target_drop;
    logic [KEY_CODE_BITS-1:0] target_key;
    logic [TCP_BITS-1:0]      target_codepoint;
    logic [MOD_BITS-1:0]      target_modifiers;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic                     keep_event;
    logic [KEY_CODE_BITS-1:0] out_key_code;
    logic [MOD_BITS-1:0]      out_modifiers;
    logic [CP_BITS-1:0]       out_layout_codepoint;
    logic [CP_BITS-1:0]       out_shifted_codepoint;
    logic [CP_BITS-1:0]       out_base_codepoint;
  } out_word_t;

  typedef struct packed {
    logic                     drop;
    logic [KEY_CODE_BITS-1:0] key;
    logic [TCP_BITS-1:0]      cp;
    logic [MOD_BITS-1:0]      mods;
  } tgt_t;

  // one table slot; held slots leave mods at zero
  typedef struct packed {
    logic                  valid;
    logic [MOD_BITS-1:0]   mods;
    logic [IDENT_BITS-1:0] ident;
    tgt_t                  tgt;
  } entry_t;

  function automatic logic [IDENT_BITS-1:0] identity_of(
    input logic [KEY_CODE_BITS-1:0] key,
    input logic [CP_BITS-1:0]       base_cp,
    input logic [CP_BITS-1:0]       lay_cp,
    input logic [KEY_CODE_BITS-1:0] print_key,
    input logic [KEY_CODE_BITS-1:0] unk_key
  );
    logic [CP_BITS-1:0]    b;
    logic [IDENT_BITS-1:0] id;
    b = (base_cp != '0) ? base_cp : lay_cp;
    if (key != print_key && key != unk_key) begin
      id = NAMED_BASE | IDENT_BITS'(key);
    end else if (b == '0 || b > CP_MAX_ASCII) begin
      id = '0;
    end else if (b >= CP_UPPER_A && b <= CP_UPPER_Z) begin
      id = IDENT_BITS'(b - CP_UPPER_A + CP_LOWER_A);
    end else begin
      id = IDENT_BITS'(b);
    end
    return id;
  endfunction

endpackage

// File: rtl/key_chord_remapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_chord_remapper
// Chord remapper: rule and held tables are rings of cells scanned at a head.
// ----------------------------------------------------------------------------
// channel | dir | handshake             | payload
// in      | in  | in_valid_i/in_ready_o   | in_data_i   (kcr_pkg::in_word_t)
// out     | out | out_valid_o/out_ready_i | out_data_o  (kcr_pkg::out_word_t)
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word at a time. Each table rotates one slot per cycle past the head
// compare: a press scans the held ring, the rule ring and, on a rule hit, the held
// ring again; repeat/release scans the held ring; a rule load scans the rule ring,
// then again to write unless the table is full; clear and others do no scan.
// Reset empties both tables at once. A waiting result does not block the
// next word; a new result waits only if the output register is still full.
// ----------------------------------------------------------------------------
module key_chord_remapper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  kcr_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output kcr_pkg::out_word_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [kcr_pkg::CFG_BITS-1:0]  cfg_data_i
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_HCLR   = 8'b0000_0010,
    S_RULE   = 8'b0000_0100,
    S_HSTO   = 8'b0000_1000,
    S_HLOOK  = 8'b0001_0000,
    S_RFIND  = 8'b0010_0000,
    S_RWRITE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [kcr_pkg::MOD_BITS-1:0]      lock_q;
  logic [kcr_pkg::KEY_CODE_BITS-1:0] pkey_q, ukey_q;

  kcr_pkg::in_word_t                 item_q;
  logic [kcr_pkg::IDENT_BITS-1:0]    ident_q;
  logic [kcr_pkg::MOD_BITS-1:0]      mm_q;
  logic [kcr_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic                              hit_q, hit_d;
  kcr_pkg::tgt_t                     tgt_q, tgt_d;
  logic                              stored_q, stored_d;
  logic                              mfound_q, mfound_d, ffound_q, ffound_d;
  logic [kcr_pkg::RULE_IW-1:0]       mslot_q, mslot_d, fslot_q, fslot_d;
  logic [kcr_pkg::RULE_IW-1:0]       slot_q, slot_d;
  logic [1:0]                        status_q, status_d;

  logic                              out_valid_q;
  kcr_pkg::out_word_t                out_q, res;

  kcr_pkg::entry_t rule_e [kcr_pkg::RULE_SLOTS];
  kcr_pkg::entry_t held_e [kcr_pkg::HELD_SLOTS];
  kcr_pkg::entry_t rule_ring, held_ring, rh, hh;
  logic            rule_shift, held_shift, clear_all;

  logic                           in_acc;
  logic [kcr_pkg::IDENT_BITS-1:0] in_ident;
  logic                           last_rule, last_held, rule_here, held_here;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_ident = kcr_pkg::identity_of(in_data_i.key_code, in_data_i.base_codepoint,
                                         in_data_i.layout_codepoint, pkey_q, ukey_q);
  assign clear_all = in_acc && (in_data_i.func == kcr_pkg::FUNC_CLEAR);

  assign rh = rule_e[0];
  assign hh = held_e[0];
  assign last_rule = (cnt_q == kcr_pkg::CNT_W'(kcr_pkg::RULE_SLOTS - 1));
  assign last_held = (cnt_q == kcr_pkg::CNT_W'(kcr_pkg::HELD_SLOTS - 1));
  assign rule_here = rh.valid && (rh.ident == ident_q);
  assign held_here = hh.valid && (hh.ident == ident_q);

  assign rule_shift = (state_q == S_RULE) || (state_q == S_RFIND) || (state_q == S_RWRITE);
  assign held_shift = (state_q == S_HCLR) || (state_q == S_HSTO) || (state_q == S_HLOOK);

  for (genvar i = 0; i < kcr_pkg::RULE_SLOTS; i++) begin : g_rule
    kcr_pkg::entry_t nxt;
    if (i == kcr_pkg::RULE_SLOTS - 1) begin : g_end
      assign nxt = rule_ring;
    end else begin : g_mid
      assign nxt = rule_e[i+1];
    end
    kcr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(rule_shift),
      .clear_i(clear_all),
      .entry_i(nxt),
      .entry_o(rule_e[i])
    );
  end

  for (genvar i = 0; i < kcr_pkg::HELD_SLOTS; i++) begin : g_held
    kcr_pkg::entry_t nxt;
    if (i == kcr_pkg::HELD_SLOTS - 1) begin : g_end
      assign nxt = held_ring;
    end else begin : g_mid
      assign nxt = held_e[i+1];
    end
    kcr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(held_shift),
      .clear_i(clear_all),
      .entry_i(nxt),
      .entry_o(held_e[i])
    );
  end

  // head processing and sequencing
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    hit_d     = hit_q;
    tgt_d     = tgt_q;
    stored_d  = stored_q;
    mfound_d  = mfound_q;
    ffound_d  = ffound_q;
    mslot_d   = mslot_q;
    fslot_d   = fslot_q;
    slot_d    = slot_q;
    status_d  = status_q;
    rule_ring = rh;
    held_ring = hh;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cnt_d    = '0;
          hit_d    = 1'b0;
          stored_d = 1'b0;
          mfound_d = 1'b0;
          ffound_d = 1'b0;
          status_d = kcr_pkg::ST_OK;
          state_d  = S_DONE;
          if (in_data_i.func == kcr_pkg::FUNC_EVENT) begin
            if (in_ident != '0) begin
              state_d = (in_data_i.action == kcr_pkg::ACT_PRESS) ? S_HCLR : S_HLOOK;
            end
          end else if (in_data_i.func == kcr_pkg::FUNC_LOAD) begin
            if (in_ident == '0) begin
              status_d = kcr_pkg::ST_NO_IDENT;
            end else begin
              state_d = S_RFIND;
            end
          end
        end
      end
      S_HCLR: begin
        if (held_here) begin
          held_ring.valid = 1'b0;
        end
        cnt_d = cnt_q + 1'b1;
        if (last_held) begin
          cnt_d   = '0;
          state_d = S_RULE;
        end
      end
      S_RULE: begin
        if (!hit_q && rule_here && rh.mods == mm_q) begin
          hit_d = 1'b1;
          tgt_d = rh.tgt;
        end
        cnt_d = cnt_q + 1'b1;
        if (last_rule) begin
          cnt_d   = '0;
          state_d = hit_d ? S_HSTO : S_DONE;
        end
      end
      S_HSTO: begin
        if (!stored_q && !hh.valid) begin
          held_ring.valid = 1'b1;
          held_ring.mods  = '0;
          held_ring.ident = ident_q;
          held_ring.tgt   = tgt_q;
          stored_d        = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (last_held) begin
          cnt_d    = '0;
          status_d = stored_d ? kcr_pkg::ST_OK : kcr_pkg::ST_HELD_FULL;
          state_d  = S_DONE;
        end
      end
      S_HLOOK: begin
        if (!hit_q && held_here) begin
          hit_d = 1'b1;
          tgt_d = hh.tgt;
          if (item_q.action == kcr_pkg::ACT_RELEASE) begin
            held_ring.valid = 1'b0;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (last_held) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end
      end
      S_RFIND: begin
        if (!mfound_q && rule_here && rh.mods == item_q.modifiers) begin
          mfound_d = 1'b1;
          mslot_d  = cnt_q[kcr_pkg::RULE_IW-1:0];
        end
        if (!ffound_q && !rh.valid) begin
          ffound_d = 1'b1;
          fslot_d  = cnt_q[kcr_pkg::RULE_IW-1:0];
        end
        cnt_d = cnt_q + 1'b1;
        if (last_rule) begin
          cnt_d  = '0;
          slot_d = mfound_d ? mslot_d : fslot_d;
          if (mfound_d || ffound_d) begin
            state_d = S_RWRITE;
          end else begin
            status_d = kcr_pkg::ST_RULE_FULL;
            state_d  = S_DONE;
          end
        end
      end
      S_RWRITE: begin
        if (cnt_q[kcr_pkg::RULE_IW-1:0] == slot_q) begin
          rule_ring.valid    = 1'b1;
          rule_ring.mods     = item_q.modifiers;
          rule_ring.ident    = ident_q;
          rule_ring.tgt.drop = item_q.target_drop;
          rule_ring.tgt.key  = item_q.target_key;
          rule_ring.tgt.cp   = item_q.target_codepoint;
          rule_ring.tgt.mods = item_q.target_modifiers;
        end
        cnt_d = cnt_q + 1'b1;
        if (last_rule) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result word
  always_comb begin
    res        = '0;
    res.status = status_q;
    if (item_q.func == kcr_pkg::FUNC_EVENT) begin
      res.keep_event            = 1'b1;
      res.out_key_code          = item_q.key_code;
      res.out_modifiers         = item_q.modifiers;
      res.out_layout_codepoint  = item_q.layout_codepoint;
      res.out_shifted_codepoint = item_q.shifted_codepoint;
      res.out_base_codepoint    = item_q.base_codepoint;
      if (hit_q) begin
        if (tgt_q.drop) begin
          res.keep_event = 1'b0;
        end else begin
          res.out_key_code          = tgt_q.key;
          res.out_modifiers         = tgt_q.mods | (item_q.modifiers & lock_q);
          res.out_layout_codepoint  = kcr_pkg::CP_BITS'(tgt_q.cp);
          res.out_shifted_codepoint = '0;
          res.out_base_codepoint    = kcr_pkg::CP_BITS'(tgt_q.cp);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      stored_q    <= 1'b0;
      mfound_q    <= 1'b0;
      ffound_q    <= 1'b0;
      status_q    <= kcr_pkg::ST_OK;
      out_valid_q <= 1'b0;
      lock_q      <= '0;
      pkey_q      <= kcr_pkg::KEY_CODE_BITS'(1);
      ukey_q      <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      hit_q    <= hit_d;
      stored_q <= stored_d;
      mfound_q <= mfound_d;
      ffound_q <= ffound_d;
      status_q <= status_d;
      if (state_q == S_DONE && state_d == S_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          kcr_pkg::CFG_LOCK_MASK: lock_q <= cfg_data_i[kcr_pkg::MOD_BITS-1:0];
          kcr_pkg::CFG_PRINT_KEY: pkey_q <= cfg_data_i[kcr_pkg::KEY_CODE_BITS-1:0];
          kcr_pkg::CFG_UNK_KEY:   ukey_q <= cfg_data_i[kcr_pkg::KEY_CODE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q   <= tgt_d;
    mslot_q <= mslot_d;
    fslot_q <= fslot_d;
    slot_q  <= slot_d;
    if (in_acc) begin
      item_q  <= in_data_i;
      ident_q <= in_ident;
      mm_q    <= in_data_i.modifiers & ~lock_q;
    end
    if (state_q == S_DONE && state_d == S_IDLE) begin
      out_q <= res;
    end
  end

endmodule

// File: rtl/kcr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcr_cell
// One table slot in a rotating ring; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module kcr_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic            clear_i,
  input  kcr_pkg::entry_t entry_i,
  output kcr_pkg::entry_t entry_o
);

  logic            valid_q;
  kcr_pkg::entry_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= entry_i;
    end
  end

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

endmodule

// File: rtl/kcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcr_checker
// Port-level checks for the chord remapper, bound to the top level.
// ----------------------------------------------------------------------------
module kcr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input kcr_pkg::out_word_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a word is in flight");

  a_full_is_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == kcr_pkg::ST_RULE_FULL |->
      !out_data_o.keep_event && out_data_o.out_key_code == '0)
    else $error("rule-full status on a non-load word");

  a_noident_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == kcr_pkg::ST_NO_IDENT |->
      !out_data_o.keep_event && out_data_o.out_modifiers == '0)
    else $error("no-identity status with event fields set");

endmodule

bind key_chord_remapper kcr_checker u_kcr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
